>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/pgwalk_pkg.sv
// shared types, codes and field layout of the page-table walker
`default_nettype none

package pgwalk_pkg;

  // store geometry
  localparam int TABLE_FRAMES_DEF  = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int ENTRY_W           = 64;
  localparam int FRAME_NUM_W       = 40;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int FLAGS_W           = 16;
  localparam int ROOT_W            = 6;
  localparam int FIRST_FREE_W      = 7;
  localparam int FRAMES_USED_W     = 7;
  localparam int FIRST_FREE_RESET  = 1;

  // entry bits: present and write set in every new intermediate entry
  localparam logic [1:0] ENTRY_PW = 2'b11;
  localparam int PTR_LSB = 12;

  // input tdata layout
  localparam int VA_LSB      = 0;
  localparam int PA_LSB      = 48;
  localparam int FL_LSB      = 100;
  localparam int UOR_BIT     = 116;
  localparam int ORF_LSB     = 117;
  localparam int IN_DATA_W   = 128;
  localparam int KIND_W      = 2;

  // output tdata layout
  localparam int ST_LSB      = 0;
  localparam int PRES_BIT    = 2;
  localparam int LEAF_LSB    = 3;
  localparam int FU_LSB      = 67;
  localparam int OUT_DATA_W  = 80;

  // configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 2'd2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_MAP       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_FLAGS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd2;

  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_NO_FRAMES   = 2'd2,
    ST_OUTSIDE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ROOT,
    S_RD,
    S_EXAM,
    S_ALLOC,
    S_PTR,
    S_FIN
  } state_t;

  // request to the shared frame adder
  typedef struct packed {
    logic                   sub;
    logic [FRAME_NUM_W-1:0] a;
    logic [FRAME_NUM_W-1:0] b;
  } alu_req_t;

  // answer of the shared frame adder
  typedef struct packed {
    logic [FRAME_NUM_W-1:0] sum;
    logic                   out_of_store;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/pgwalk_ram.sv
// generic single-port ram with registered read
`default_nettype none

module pgwalk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle: a write also reads out the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> rtl/pgwalk_alu.sv
// shared 40-bit frame adder with store range compare
`default_nettype none

module pgwalk_alu
  import pgwalk_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  localparam logic [FRAME_NUM_W-1:0] LIMIT = FRAME_NUM_W'(TABLE_FRAMES);

  logic [FRAME_NUM_W-1:0] sum;

  // add for root and allocation, subtract for pointer to frame, modulo 2^40
  assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);

  assign rsp.sum          = sum;
  assign rsp.out_of_store = (sum >= LIMIT);

endmodule

`default_nettype wire

>>> rtl/pgwalk_ctrl.sv
// walk sequencer, request and result registers, configuration registers
`default_nettype none

module pgwalk_ctrl
  import pgwalk_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF,
  localparam int FRAME_W = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1,
  localparam int ADDR_W  = FRAME_W + IDX_W,
  localparam int NF_W    = ($clog2(TABLE_FRAMES + 1) > FIRST_FREE_W) ?
                           $clog2(TABLE_FRAMES + 1) : FIRST_FREE_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [KIND_W-1:0]     s_tuser,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output alu_req_t                   alu_req,
  input  wire alu_rsp_t              alu_rsp,
  output logic                       ram_we,
  output logic      [ADDR_W-1:0]     ram_addr,
  output logic      [ENTRY_W-1:0]    ram_wdata,
  input  wire logic [ENTRY_W-1:0]    ram_rdata
);

  localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [NF_W-1:0]   NF_LIMIT = NF_W'(TABLE_FRAMES);

  state_t state, state_next;

  // control and configuration registers
  logic [ADDR_W-1:0]      clr_cnt;
  logic [NF_W-1:0]        nf;
  logic [ROOT_W-1:0]      root_q;
  logic [FRAME_NUM_W-1:0] base_q;

  // request registers
  logic [KIND_W-1:0]      kind_q;
  logic [VA_W-1:0]        va_q;
  logic [PA_W-1:0]        pa_q;
  logic [FLAGS_W-1:0]     fl_q;
  logic [ROOT_W-1:0]      root_sel_q;

  // walk registers
  logic [1:0]             level;
  logic [FRAME_W-1:0]     frame_q;
  logic [FRAME_NUM_W-1:0] ptr_q;

  // result held until the output register is free
  status_t                res_status;
  logic                   res_present;
  logic [ENTRY_W-1:0]     res_leaf;

  // output register
  status_t                status_q;
  logic                   present_q;
  logic [ENTRY_W-1:0]     leaf_q;
  logic [FRAMES_USED_W-1:0] fu_q;

  logic [IDX_W-1:0]       lvl_idx;
  logic [ADDR_W-1:0]      walk_addr;
  logic [ENTRY_W-1:0]     leaf_val;
  logic [ENTRY_W-1:0]     alloc_entry;
  logic                   is_alloc;
  logic                   is_leaf;
  logic                   nf_full;
  logic                   accept;
  logic                   out_load;

  // table index for the current level
  always_comb begin
    case (level)
      2'd0:    lvl_idx = va_q[39 +: IDX_W];
      2'd1:    lvl_idx = va_q[30 +: IDX_W];
      2'd2:    lvl_idx = va_q[21 +: IDX_W];
      default: lvl_idx = va_q[12 +: IDX_W];
    endcase
  end

  assign walk_addr   = {frame_q, lvl_idx};
  assign is_alloc    = (kind_q != KIND_QUERY);
  assign is_leaf     = (level == LEVEL_LEAF);
  assign nf_full     = (nf >= NF_LIMIT);
  assign accept      = s_tvalid && s_tready;
  assign alloc_entry = {12'd0, alu_rsp.sum, 10'd0, ENTRY_PW};

  // new leaf value by request kind
  always_comb begin
    case (kind_q)
      KIND_MAP:       leaf_val = {12'd0, pa_q} | {48'd0, fl_q};
      KIND_SET_FLAGS: leaf_val = ram_rdata | {48'd0, fl_q};
      default:        leaf_val = ram_rdata;
    endcase
  end

  // next state, memory port and adder control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = walk_addr;
    ram_wdata  = leaf_val;
    alu_req    = '{sub: 1'b0, a: '0, b: '0};
    out_load   = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == KIND_MAP || s_tuser == KIND_SET_FLAGS || s_tuser == KIND_QUERY) begin
            state_next = S_ROOT;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_ROOT: begin
        alu_req.a = FRAME_NUM_W'(root_sel_q);
        state_next = alu_rsp.out_of_store ? S_FIN : S_RD;
      end
      S_RD: begin
        state_next = S_EXAM;
      end
      S_EXAM: begin
        if (is_leaf) begin
          ram_we     = is_alloc;
          state_next = S_FIN;
        end else if (is_alloc) begin
          if (ram_rdata == '0) begin
            state_next = nf_full ? S_FIN : S_ALLOC;
          end else begin
            state_next = S_PTR;
          end
        end else begin
          state_next = ram_rdata[0] ? S_PTR : S_FIN;
        end
      end
      S_ALLOC: begin
        alu_req.a  = base_q;
        alu_req.b  = FRAME_NUM_W'(nf);
        ram_we     = 1'b1;
        ram_wdata  = alloc_entry;
        state_next = S_PTR;
      end
      S_PTR: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ptr_q;
        alu_req.b   = base_q;
        state_next  = alu_rsp.out_of_store ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing sweep, allocator, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      nf       <= NF_W'(FIRST_FREE_RESET);
      root_q   <= '0;
      base_q   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_ALLOC) begin
        nf <= nf + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROOT:       root_q <= cfg_data[ROOT_W-1:0];
          CFG_BASE:       base_q <= cfg_data[FRAME_NUM_W-1:0];
          CFG_FIRST_FREE: nf     <= NF_W'(cfg_data[FIRST_FREE_W-1:0]);
          default:        ;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request capture and walk datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          kind_q      <= s_tuser;
          va_q        <= s_tdata[VA_LSB +: VA_W];
          pa_q        <= s_tdata[PA_LSB +: PA_W];
          fl_q        <= s_tdata[FL_LSB +: FLAGS_W];
          root_sel_q  <= s_tdata[UOR_BIT] ? s_tdata[ORF_LSB +: ROOT_W] : root_q;
          level       <= 2'd0;
          res_status  <= ST_OK;
          res_present <= 1'b0;
          res_leaf    <= '0;
        end
      end
      S_ROOT: begin
        if (alu_rsp.out_of_store) begin
          res_status <= ST_OUTSIDE;
        end
        frame_q <= alu_rsp.sum[FRAME_W-1:0];
      end
      S_EXAM: begin
        if (is_leaf) begin
          res_leaf <= leaf_val;
          if (!is_alloc) begin
            res_present <= ram_rdata[0];
            res_status  <= ram_rdata[0] ? ST_OK : ST_NOT_PRESENT;
          end
        end else if (is_alloc) begin
          if (ram_rdata == '0 && nf_full) begin
            res_status <= ST_NO_FRAMES;
          end
        end else if (!ram_rdata[0]) begin
          res_status <= ST_NOT_PRESENT;
        end
        ptr_q <= ram_rdata[PTR_LSB +: FRAME_NUM_W];
      end
      S_ALLOC: begin
        ptr_q <= alu_rsp.sum;
      end
      S_PTR: begin
        if (alu_rsp.out_of_store) begin
          res_status <= ST_OUTSIDE;
        end
        frame_q <= alu_rsp.sum[FRAME_W-1:0];
        level   <= level + 1'b1;
      end
      default: ;
    endcase
  end

  // output register load
  always_ff @(posedge clk) begin
    if (out_load) begin
      status_q  <= res_status;
      present_q <= res_present;
      leaf_q    <= res_leaf;
      fu_q      <= nf[FRAMES_USED_W-1:0];
    end
  end

  assign m_tdata = {6'd0, fu_q, leaf_q, present_q, status_q};

endmodule

`default_nettype wire

>>> rtl/four_level_page_table_walker_unit.sv
// four-level page-table walker over an internal single-port table store
// after reset the store is cleared one entry a cycle, and s_tready first rises
// when the sweep is done; config writes are taken during the sweep too
// a walk does the root add, then per level a ram read and an examine, with an
// allocation for a missing table and a pointer subtract above the leaf, and stops
// early on an abort; an unused kind goes straight to the result; one request at a time
`default_nettype none

module four_level_page_table_walker_unit
  import pgwalk_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // kind[1:0]
  input  wire logic [KIND_W-1:0]     s_tuser,
  // vaddr[47:0], paddr[99:48], flags[115:100],
  // use_other_root[116], other_root_frame[122:117], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // status[1:0], present[2], leaf_entry[66:3], frames_used[73:67], zero fill
  output logic      [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FRAME_W = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int ADDR_W  = FRAME_W + IDX_W;
  localparam int DEPTH   = TABLE_FRAMES * ENTRIES_PER_TABLE;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // sequencer
  pgwalk_ctrl #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // shared frame adder
  pgwalk_alu #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // table store
  pgwalk_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/pgwalk_checker.sv
// port-level checks on the page-table walker and their bind
`default_nettype none

`include "assert_macros.svh"

module pgwalk_checker
  import pgwalk_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  logic [1:0] st;
  logic       pres;
  logic       leaf_zero;

  assign st        = m_tdata[ST_LSB +: 2];
  assign pres      = m_tdata[PRES_BIT];
  assign leaf_zero = (m_tdata[LEAF_LSB +: ENTRY_W] == '0);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // one request at a time: busy right after a transfer in
  `ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)
  // a present answer always comes with ok status
  `ASSERT_SAME(a_present_ok, m_tvalid && pres, st == ST_OK)
  // an aborted walk never reports a leaf
  `ASSERT_SAME(a_abort_no_leaf, m_tvalid && (st == ST_NO_FRAMES || st == ST_OUTSIDE), leaf_zero)

endmodule

bind four_level_page_table_walker_unit pgwalk_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/pgwalk_tracker_pkg.sv
// request layout and the page-walk predictor with its queue of awaited results
package pgwalk_tracker_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import pgwalk_pkg::*;

  // one request as it travels on the input stream
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VA_W-1:0]    va;
    logic [PA_W-1:0]    pa;
    logic [FLAGS_W-1:0] flags;
    logic               use_other;
    logic [ROOT_W-1:0]  other_root;
  } walk_req_t;

  // one result as the block should return it
  typedef struct {
    status_t                  status;
    bit                       present;
    bit [ENTRY_W-1:0]         leaf;
    bit [FRAMES_USED_W-1:0]   frames_used;
  } walk_rsp_t;

  class page_walk_tracker;
    bit [ENTRY_W-1:0]      table_mem [TABLE_FRAMES_DEF*ENTRIES_PER_TABLE];
    bit [ROOT_W-1:0]       root_frame;
    bit [FRAME_NUM_W-1:0]  base_frame;
    int unsigned           next_free;
    walk_rsp_t             awaited_results[$];
    int unsigned           errors;

    function new();
      root_frame = '0;
      base_frame = '0;
      next_free  = FIRST_FREE_RESET;
      errors     = 0;
    endfunction

    // register write, issued while the block is idle or still clearing its store
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_ROOT: root_frame = value[ROOT_W-1:0];
        CFG_BASE: base_frame = value[FRAME_NUM_W-1:0];
        CFG_FIRST_FREE: next_free = value[FIRST_FREE_W-1:0];
        default: ;
      endcase
    endfunction

    // 9-bit table index for level 0 (top) to 3 (leaf)
    function int unsigned level_index(bit [VA_W-1:0] va, int lv);
      return int'((va >> (PTR_LSB + IDX_W*(3-lv))) & (ENTRIES_PER_TABLE-1));
    endfunction

    // walk the three upper levels, growing missing tables when asked
    function status_t walk(bit [VA_W-1:0] va, int unsigned start, bit grow,
                           output int unsigned leaf_pos);
      int unsigned          frame_now;
      int unsigned          pos;
      bit [ENTRY_W-1:0]     ent;
      bit [FRAME_NUM_W-1:0] pfn;
      bit [FRAME_NUM_W-1:0] target;
      leaf_pos  = 0;
      frame_now = start;
      if (frame_now >= TABLE_FRAMES_DEF) return ST_OUTSIDE;
      for (int lv = 0; lv < 3; lv++) begin
        pos = frame_now*ENTRIES_PER_TABLE + level_index(va, lv);
        ent = table_mem[pos];
        if (grow) begin
          if (ent == '0) begin
            if (next_free >= TABLE_FRAMES_DEF) return ST_NO_FRAMES;
            pfn = base_frame + FRAME_NUM_W'(next_free);
            ent = '0;
            ent[PTR_LSB +: FRAME_NUM_W] = pfn;
            ent[1:0] = ENTRY_PW;
            next_free++;
            table_mem[pos] = ent;
          end
        end else if (!ent[0]) begin
          return ST_NOT_PRESENT;
        end
        // pointer taken from bits 51:12, relative to the store base, wrapping
        target = ent[PTR_LSB +: FRAME_NUM_W] - base_frame;
        if (target >= TABLE_FRAMES_DEF) return ST_OUTSIDE;
        frame_now = int'(target);
      end
      leaf_pos = frame_now*ENTRIES_PER_TABLE + level_index(va, 3);
      return ST_OK;
    endfunction

    // accepted request: update the model store and queue the awaited result
    function void note_request(walk_req_t rq);
      int unsigned slot;
      int unsigned start;
      status_t     st;
      walk_rsp_t   rsp;
      start = rq.use_other ? int'(rq.other_root) : int'(root_frame);
      rsp.status  = ST_OK;
      rsp.present = 1'b0;
      rsp.leaf    = '0;
      if (rq.kind == KIND_MAP || rq.kind == KIND_SET_FLAGS) begin
        st = walk(rq.va, start, 1'b1, slot);
        if (st == ST_OK) begin
          if (rq.kind == KIND_MAP)
            table_mem[slot] = ENTRY_W'(rq.pa) | ENTRY_W'(rq.flags);
          else
            table_mem[slot] = table_mem[slot] | ENTRY_W'(rq.flags);
          rsp.leaf = table_mem[slot];
        end
        rsp.status = st;
      end else if (rq.kind == KIND_QUERY) begin
        st = walk(rq.va, start, 1'b0, slot);
        if (st == ST_OK) begin
          rsp.leaf = table_mem[slot];
          if (rsp.leaf[0]) rsp.present = 1'b1;
          else st = ST_NOT_PRESENT;
        end
        rsp.status = st;
      end
      rsp.frames_used = FRAMES_USED_W'(next_free);
      awaited_results.push_back(rsp);
    endfunction

    // result transfer: compare field by field with the oldest awaited result
    function void check_result(logic [OUT_DATA_W-1:0] data);
      walk_rsp_t exp_rsp;
      status_t   got_status;
      logic      got_present;
      logic [ENTRY_W-1:0]       got_leaf;
      logic [FRAMES_USED_W-1:0] got_used;
      got_status  = status_t'(data[ST_LSB +: 2]);
      got_present = data[PRES_BIT];
      got_leaf    = data[LEAF_LSB +: ENTRY_W];
      got_used    = data[FU_LSB +: FRAMES_USED_W];
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none awaited, got data %h", $time, data);
        errors++;
        return;
      end
      exp_rsp = awaited_results.pop_front();
      if (got_status !== exp_rsp.status) begin
        $display("%0t: status expected %0d got %0d", $time, exp_rsp.status, got_status);
        errors++;
      end
      if (got_present !== exp_rsp.present) begin
        $display("%0t: present expected %0d got %0d", $time, exp_rsp.present, got_present);
        errors++;
      end
      if (got_leaf !== exp_rsp.leaf) begin
        $display("%0t: leaf entry expected %h got %h", $time, exp_rsp.leaf, got_leaf);
        errors++;
      end
      if (got_used !== exp_rsp.frames_used) begin
        $display("%0t: frames used expected %0d got %0d", $time, exp_rsp.frames_used,
                 got_used);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction
  endclass

endpackage

>>> sim/tb_four_level_page_table_walker_unit.sv
// testbench top: drives walk requests and config writes, checks every result transfer
module tb_four_level_page_table_walker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pgwalk_pkg::*;
  import pgwalk_tracker_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // walk time grows with each new table allocated
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [KIND_W-1:0]     s_tuser   = '0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  page_walk_tracker tracker = new();

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_asked         = 0;
  int unsigned hold_taken         = 0;
  int unsigned hold_left          = 0;

  // address pools so most random walks share upper tables
  logic [IDX_W-1:0] pool_l4 [2];
  logic [IDX_W-1:0] pool_l3 [2];
  logic [IDX_W-1:0] pool_l2 [3];
  logic [VA_W-1:0]  mapped_va [$];

  four_level_page_table_walker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls, plus a long hold-off counted here when asked
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watch both streams and the config port
  always @(posedge clk) begin
    walk_req_t rq;
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
      if (s_tvalid && s_tready) begin
        rq.kind       = s_tuser;
        rq.va         = s_tdata[VA_LSB +: VA_W];
        rq.pa         = s_tdata[PA_LSB +: PA_W];
        rq.flags      = s_tdata[FL_LSB +: FLAGS_W];
        rq.use_other  = s_tdata[UOR_BIT];
        rq.other_root = s_tdata[ORF_LSB +: ROOT_W];
        tracker.note_request(rq);
      end
      if (cfg_we) tracker.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one request after a random gap, return at its transfer
  task automatic send_walk(walk_req_t rq);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[VA_LSB +: VA_W]     = rq.va;
    d[PA_LSB +: PA_W]     = rq.pa;
    d[FL_LSB +: FLAGS_W]  = rq.flags;
    d[UOR_BIT]            = rq.use_other;
    d[ORF_LSB +: ROOT_W]  = rq.other_root;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq.kind;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait for every awaited result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly pooled addresses and recently mapped pages, a little noise
  function automatic walk_req_t random_walk();
    walk_req_t   rq;
    int unsigned roll;
    logic [63:0] wide;
    roll = $urandom_range(99);
    if (roll < 40)      rq.kind = KIND_MAP;
    else if (roll < 62) rq.kind = KIND_SET_FLAGS;
    else if (roll < 95) rq.kind = KIND_QUERY;
    else                rq.kind = KIND_UNUSED;
    wide = {$urandom, $urandom};
    if (mapped_va.size() != 0 && $urandom_range(1) == 1)
      rq.va = mapped_va[$urandom_range(mapped_va.size()-1)];
    else if ($urandom_range(9) == 0)
      rq.va = wide[VA_W-1:0];
    else
      rq.va = {pool_l4[$urandom_range(1)], pool_l3[$urandom_range(1)],
               pool_l2[$urandom_range(2)], wide[20:0]};
    wide = {$urandom, $urandom};
    rq.pa = wide[PA_W-1:0];
    rq.flags = FLAGS_W'($urandom);
    if ($urandom_range(4) != 0) rq.flags[0] = 1'b1;
    rq.use_other  = ($urandom_range(9) == 0);
    rq.other_root = ROOT_W'($urandom);
    if (rq.kind == KIND_MAP && !rq.use_other) begin
      mapped_va.push_back(rq.va);
      if (mapped_va.size() > 32) void'(mapped_va.pop_front());
    end
    return rq;
  endfunction

  // one random phase under a given setting and idling mix
  task automatic run_phase(logic [ROOT_W-1:0] root, logic [FRAME_NUM_W-1:0] base,
                           logic [FIRST_FREE_W-1:0] first_free, int items,
                           int unsigned idle_pct, int unsigned stall_pct, bit with_hold);
    settle();
    write_reg(CFG_ROOT, CFG_DATA_W'(root));
    write_reg(CFG_BASE, CFG_DATA_W'(base));
    write_reg(CFG_FIRST_FREE, CFG_DATA_W'(first_free));
    sender_idle_pct = idle_pct;
    receiver_stall_pct <= stall_pct;
    foreach (pool_l4[k]) pool_l4[k] = IDX_W'($urandom);
    foreach (pool_l3[k]) pool_l3[k] = IDX_W'($urandom);
    foreach (pool_l2[k]) pool_l2[k] = IDX_W'($urandom);
    mapped_va.delete();
    for (int i = 0; i < items; i++) begin
      // long receiver hold-off while requests keep coming, later a full pause
      if (with_hold && i == items/4) hold_asked <= hold_asked + 1;
      if (with_hold && i == items/2) drain();
      send_walk(random_walk());
    end
  endtask

  initial begin
    #5_000_000;
    $display("tb_four_level_page_table_walker_unit: done, errors");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // registers are taken while the store is still being cleared
    write_reg(CFG_ROOT, '0);
    write_reg(CFG_BASE, '0);
    write_reg(CFG_FIRST_FREE, CFG_DATA_W'(FIRST_FREE_RESET));

    // empty store, then grow the path for address zero step by step
    send_walk(walk_req_t'{KIND_QUERY, 48'h0, 52'h0, 16'h0, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_MAP, 48'h0, 52'h0, 16'h0, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_QUERY, 48'h0, 52'h0, 16'h0, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_SET_FLAGS, 48'h0, 52'h0, 16'h1, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_QUERY, 48'h0, 52'h0, 16'h0, 1'b0, 6'd0});
    // all-ones fields
    send_walk(walk_req_t'{KIND_MAP, '1, '1, '1, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_SET_FLAGS, '1, '1, 16'h0, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_QUERY, '1, '0, '0, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_UNUSED, '1, '1, '1, 1'b1, '1});
    // leaf table of address zero used as a top table: nonzero but not present
    send_walk(walk_req_t'{KIND_MAP, 48'h5000, 52'h5000, 16'h2, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_MAP, 48'h0280_0000_0000, 52'h1234, 16'h1, 1'b1, 6'd3});
    send_walk(walk_req_t'{KIND_QUERY, 48'h0280_0000_0000, 52'h0, 16'h0, 1'b1, 6'd3});
    // pointer to a frame outside the store
    send_walk(walk_req_t'{KIND_MAP, 48'h6000, 52'h10_0000, 16'h1, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_QUERY, 48'h0300_0000_0000, 52'h0, 16'h0, 1'b1, 6'd3});
    send_walk(walk_req_t'{KIND_SET_FLAGS, 48'h0300_0000_0000, 52'h0, 16'h4, 1'b1, 6'd3});
    // alternative root at the top of the store
    send_walk(walk_req_t'{KIND_MAP, 48'h1234_5678_9000, 52'hA_BCDE_F000, 16'h3, 1'b1, 6'd63});
    send_walk(walk_req_t'{KIND_QUERY, 48'h1234_5678_9000, 52'h0, 16'h0, 1'b1, 6'd63});

    // allocator running dry part way through a walk
    settle();
    write_reg(CFG_FIRST_FREE, CFG_DATA_W'(62));
    send_walk(walk_req_t'{KIND_MAP, 48'h8000_0000_0000, 52'h7000, 16'h1, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_QUERY, 48'h8000_0000_0000, 52'h0, 16'h0, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_SET_FLAGS, 48'h8000_0020_0000, 52'h0, 16'h1, 1'b0, 6'd0});
    send_walk(walk_req_t'{KIND_UNUSED, 48'h0, 52'h0, 16'h0, 1'b0, 6'd0});

    // random phases across settings and idling mixes
    run_phase(6'd0, 40'h0, 7'd1, 105, 0, 0, 1'b0);
    run_phase(6'd0, 40'hFF_FFFF_FFFE, 7'd40, 105, 74, 0, 1'b0);
    run_phase(6'd63, 40'h12_3456_789A, 7'd20, 105, 0, 74, 1'b1);
    run_phase(6'd0, 40'h0, 7'd64, 105, 9, 9, 1'b0);
    run_phase(6'd17, 40'hFF_FFFF_FFFF, 7'd0, 105, 9, 9, 1'b0);
    run_phase(6'd0, 40'h0, 7'd1, 105, 0, 0, 1'b1);
    run_phase(ROOT_W'($urandom), FRAME_NUM_W'($urandom_range(63)),
              FIRST_FREE_W'($urandom_range(64)), 105, 74, 0, 1'b0);
    run_phase(6'd5, 40'h0, 7'd63, 105, 0, 74, 1'b0);

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_four_level_page_table_walker_unit: done, clean");
    end else begin
      $display("tb_four_level_page_table_walker_unit: done, errors");
    end
    $finish;
  end

endmodule
